// ===== src/lrc_pkg.sv =====
package lrc_pkg;

   localparam int DEF_ENTRIES = 16;
   localparam int KEY_W       = 32;
   localparam int VALUE_W     = 32;
   localparam int CAP_W       = 5;

   localparam logic [CAP_W-1:0]   CAP_RESET  = 5'd16;
   localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

   // operation codes carried in the kind field
   localparam logic KIND_GET = 1'b0;
   localparam logic KIND_PUT = 1'b1;

   typedef struct packed {
      logic                      kind;
      logic signed [KEY_W-1:0]   key;
      logic signed [VALUE_W-1:0] value;
   } lrc_op_type;

   typedef struct packed {
      logic                      hit;
      logic signed [VALUE_W-1:0] read_value;
   } lrc_result_type;

endpackage

// ===== src/lrc_channels.sv =====
interface lrc_req_if import lrc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic signed [KEY_W-1:0]   key;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, kind, key, value, input ready);
   modport sink   (input valid, kind, key, value, output ready);
endinterface

interface lrc_rsp_if import lrc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      hit;
   logic signed [VALUE_W-1:0] read_value;

   modport source (output valid, hit, read_value, input ready);
   modport sink   (input valid, hit, read_value, output ready);
endinterface

interface lrc_csr_if import lrc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== src/lrc_store.sv =====
module lrc_store import lrc_pkg::*; #(
   parameter int ENTRIES = DEF_ENTRIES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  lrc_op_type       op,
   input  logic [CAP_W-1:0] capacity,
   output lrc_result_type   result,
   output logic             empty
);

   localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int COUNT_W = $clog2(ENTRIES + 1);

   logic [ENTRIES-1:0]        valid_ff, valid_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic signed [KEY_W-1:0]   key_ff   [ENTRIES];
   logic signed [VALUE_W-1:0] value_ff [ENTRIES];
   logic [RANK_W-1:0]         rank_ff  [ENTRIES];

   logic [COUNT_W-1:0]        cap_eff;
   logic [RANK_W-1:0]         victim_rank;
   logic [RANK_W-1:0]         hit_rank;
   logic [VALUE_W-1:0]        hit_value;
   logic [ENTRIES-1:0]        match, free_oh, victim_oh, sel;
   logic                      hit, has_room, is_put, do_update, do_write;

   // clamp capacity into 1 .. ENTRIES
   always_comb begin
      if (capacity == '0) begin
         cap_eff = COUNT_W'(1);
      end else if (int'(capacity) > ENTRIES) begin
         cap_eff = COUNT_W'(ENTRIES);
      end else begin
         cap_eff = COUNT_W'(capacity);
      end
   end

   assign victim_rank = RANK_W'(count_ff - COUNT_W'(1));

   // parallel compare; keys are unique so match is one-hot
   always_comb begin
      hit_rank  = '0;
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]     = valid_ff[i] && (key_ff[i] == op.key);
         victim_oh[i] = valid_ff[i] && (rank_ff[i] == victim_rank);
         hit_rank     = hit_rank | (match[i] ? rank_ff[i] : '0);
         hit_value    = hit_value | ({VALUE_W{match[i]}} & value_ff[i]);
      end
   end

   // lowest free slot
   assign free_oh = ~valid_ff & (valid_ff + ENTRIES'(1));

   assign hit       = |match;
   assign has_room  = count_ff < cap_eff;
   assign is_put    = op.kind == KIND_PUT;
   assign do_update = go && (is_put || hit);
   assign do_write  = go && is_put;
   assign sel       = hit ? match : (has_room ? free_oh : victim_oh);

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      if (do_write) begin
         valid_in = valid_ff | sel;
         if (!hit && has_room) begin
            count_in = count_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   // promote the selected entry, age the ones ahead of it
   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (do_update) begin
            if (sel[i]) begin
               rank_ff[i] <= '0;
            end else if (valid_ff[i] && (!hit || rank_ff[i] < hit_rank)) begin
               rank_ff[i] <= rank_ff[i] + RANK_W'(1);
            end
         end
         if (do_write && sel[i]) begin
            key_ff[i]   <= op.key;
            value_ff[i] <= op.value;
         end
      end
   end

   assign result.hit        = hit;
   assign result.read_value = hit ? hit_value : MISS_VALUE;
   assign empty             = count_ff == '0;

endmodule

// ===== src/lru_key_value_cache_top.sv =====
// Fully associative key-value cache with LRU replacement.
// A get word passes through the request register and then the response register.
// Throughput: one word per cycle unless a get waits on a stalled response; the
// key compare and rank update of all entries lie between the two registers.
// Reset: synchronous, active high; empties the store, capacity returns to 16.
module lru_key_value_cache_top import lrc_pkg::*; #(
   parameter int ENTRIES = DEF_ENTRIES
) (
   input  logic     clock,
   input  logic     reset,
   lrc_req_if.sink   req_bus,
   lrc_rsp_if.source rsp_bus,
   lrc_csr_if.sink   csr_bus
);

   // request register
   logic             req_vld_ff, req_vld_in;
   lrc_op_type       req_op_ff;

   // response register
   logic             rsp_vld_ff, rsp_vld_in;
   lrc_result_type   rsp_res_ff;
   lrc_result_type   result;

   logic [CAP_W-1:0] capacity_ff;
   logic             empty;
   logic             advance;
   logic             accept;
   logic             load_rsp;

   // A put leaves the request register freely; a get needs room in the
   // response register (empty, or being drained this cycle).
   assign advance = req_vld_ff &&
                    (req_op_ff.kind == KIND_PUT || !rsp_vld_ff || rsp_bus.ready);

   assign req_bus.ready = !req_vld_ff || advance;
   assign accept        = req_bus.valid && req_bus.ready;
   assign load_rsp      = advance && (req_op_ff.kind == KIND_GET);

   assign req_vld_in = accept || (req_vld_ff && !advance);
   assign rsp_vld_in = load_rsp || (rsp_vld_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         capacity_ff <= CAP_RESET;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         // drop capacity writes unless the store is empty
         if (csr_bus.valid && empty) begin
            capacity_ff <= csr_bus.data;
         end
      end
   end

   // payload: hold the request word, capture the response word
   always_ff @(posedge clock) begin
      if (accept) begin
         req_op_ff.kind  <= req_bus.kind;
         req_op_ff.key   <= req_bus.key;
         req_op_ff.value <= req_bus.value;
      end
      if (load_rsp) begin
         rsp_res_ff <= result;
      end
   end

   lrc_store #(
      .ENTRIES (ENTRIES)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .go       (advance),
      .op       (req_op_ff),
      .capacity (capacity_ff),
      .result   (result),
      .empty    (empty)
   );

   assign csr_bus.ready      = 1'b1;
   assign rsp_bus.valid      = rsp_vld_ff;
   assign rsp_bus.hit        = rsp_res_ff.hit;
   assign rsp_bus.read_value = rsp_res_ff.read_value;

endmodule

// ===== src/lrc_checker.sv =====
module lrc_checker import lrc_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_kind,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_hit,
   input logic [VALUE_W-1:0] rsp_read_value
);

   // an empty response side never blocks requests
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response side");

   // a fresh response comes from a get that passed straight through the request register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_kind == KIND_GET, 2))
      else $error("response without a matching get");

   // a miss carries all ones
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_read_value == MISS_VALUE)
      else $error("miss response with wrong value");

   // hold a stalled response word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_read_value))
      else $error("stalled response changed");

endmodule

bind lru_key_value_cache_top lrc_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .req_kind       (req_bus.kind),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_hit        (rsp_bus.hit),
   .rsp_read_value (rsp_bus.read_value)
);

// ===== test/lru_key_value_cache_top_test.sv =====
module lru_key_value_cache_top_test import lrc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // Cycles with no handshake on any channel before the run is declared hung.
   // The longest legal quiet stretch is the receiver hold-off of HOLD_OFF_CYCLES.
   localparam int IDLE_LIMIT      = 2000;
   localparam int HOLD_OFF_CYCLES = 150;
   // A put leaves no response behind, so let the pipeline empty out before
   // touching the capacity register.
   localparam int SETTLE_CYCLES   = 4;

   logic clock;
   logic reset;

   lrc_req_if req_bus ();
   lrc_rsp_if rsp_bus ();
   lrc_csr_if csr_bus ();

   lru_key_value_cache_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Shadow copy of the cache contents, ranks and capacity register.
   // Rank 0 is the most recent entry; valid entries hold ranks 0..count-1.
   logic [KEY_W-1:0]   shadow_keys   [DEF_ENTRIES];
   logic [VALUE_W-1:0] shadow_values [DEF_ENTRIES];
   bit                 shadow_valid  [DEF_ENTRIES];
   int unsigned        shadow_rank   [DEF_ENTRIES];
   int unsigned        shadow_count;
   logic [CAP_W-1:0]   shadow_capacity;

   // Responses still owed by the cache, one per accepted get, oldest first.
   lrc_result_type expected_lookups [$];

   // Keys reused by random traffic so that hits, updates and evictions occur.
   logic [KEY_W-1:0] key_pool [$];
   logic [KEY_W-1:0] corner_words [4] = '{32'h8000_0000, 32'h7fff_ffff,
                                          32'h0000_0000, 32'hffff_ffff};

   int send_idle_pct;
   int recv_stall_pct;
   int rsp_hold_cycles;
   int error_count;
   int quiet_cycles;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Zero and out-of-range capacity values clamp to the legal range.
   function automatic int unsigned usable_entries();
      int unsigned cap;
      cap = {{(32-CAP_W){1'b0}}, shadow_capacity};
      if (cap == 0) cap = 1;
      if (cap > DEF_ENTRIES) cap = DEF_ENTRIES;
      return cap;
   endfunction

   // Move a slot to the front: every other valid entry more recent than
   // limit ages by one.
   function automatic void promote_entry(int slot, int unsigned limit);
      for (int i = 0; i < DEF_ENTRIES; i++) begin
         if (shadow_valid[i] && i != slot && shadow_rank[i] < limit)
            shadow_rank[i]++;
      end
      shadow_rank[slot] = 0;
   endfunction

   // Apply one accepted request word to the shadow cache and queue the
   // response a get owes.
   function automatic void predict_cache_op(lrc_op_type op);
      int             slot;
      lrc_result_type res;
      slot = -1;
      for (int i = 0; i < DEF_ENTRIES; i++) begin
         if (slot < 0 && shadow_valid[i] && shadow_keys[i] == op.key)
            slot = i;
      end

      if (op.kind == KIND_GET) begin
         if (slot < 0) begin
            // Miss: all ones, no change to the ranks.
            res.hit        = 1'b0;
            res.read_value = MISS_VALUE;
         end else begin
            promote_entry(slot, shadow_rank[slot]);
            res.hit        = 1'b1;
            res.read_value = shadow_values[slot];
         end
         expected_lookups.push_back(res);
         return;
      end

      // Put on a present key: overwrite in place and refresh.
      if (slot >= 0) begin
         shadow_values[slot] = op.value;
         promote_entry(slot, shadow_rank[slot]);
         return;
      end

      if (shadow_count < usable_entries()) begin
         // Room left: take the lowest free slot.
         for (int i = 0; i < DEF_ENTRIES; i++) begin
            if (slot < 0 && !shadow_valid[i]) slot = i;
         end
         shadow_count++;
      end else begin
         // Full: replace the least recent entry in place.
         for (int i = 0; i < DEF_ENTRIES; i++) begin
            if (slot < 0 && shadow_valid[i] && shadow_rank[i] == shadow_count - 1)
               slot = i;
         end
      end
      if (slot < 0) slot = 0;
      promote_entry(slot, DEF_ENTRIES + 1);
      shadow_valid[slot]  = 1'b1;
      shadow_keys[slot]   = op.key;
      shadow_values[slot] = op.value;
   endfunction

   // ------------------------------------------------------------------------
   // Clock, response sink, checker and watchdog
   // ------------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Drive the response ready: a long hold-off when one is requested,
   // otherwise stall at random with the phase's probability.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_hold_cycles > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Compare every accepted response word with the oldest expectation.
   always @(posedge clock) begin : check_responses
      lrc_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_lookups.size() == 0) begin
            $error("response word with no get outstanding: hit %0b read_value %h",
                   rsp_bus.hit, rsp_bus.read_value);
            error_count++;
         end else begin
            want = expected_lookups.pop_front();
            if (rsp_bus.hit !== want.hit) begin
               $error("hit: expected %0b, actual %0b", want.hit, rsp_bus.hit);
               error_count++;
            end
            if (rsp_bus.read_value !== want.read_value) begin
               $error("read_value: expected %h, actual %h",
                      want.read_value, rsp_bus.read_value);
               error_count++;
            end
         end
      end
   end

   // Drop the run if no word moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Shared driving tasks
   // ------------------------------------------------------------------------

   // Offer one request word, idling first at the phase's rate, and hold it
   // until the cache takes it. Valid stays high on return so back-to-back
   // words need no gap.
   task automatic send_word(input logic kind, input logic [KEY_W-1:0] key,
                            input logic [VALUE_W-1:0] value);
      lrc_op_type op;
      op.kind  = kind;
      op.key   = key;
      op.value = value;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind  <= kind;
      req_bus.key   <= key;
      req_bus.value <= value;
      do @(posedge clock); while (!req_bus.ready);
      predict_cache_op(op);
   endtask

   // Stop offering and wait for every owed response, then let trailing puts
   // leave the pipeline.
   task automatic settle_cache();
      req_bus.valid <= 1'b0;
      while (expected_lookups.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the capacity register with the cache idle. The cache only takes
   // the value while empty; mirror that in the shadow copy.
   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      settle_cache();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= cap;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      if (shadow_count == 0) shadow_capacity = cap;
   endtask

   // Pick a key: mostly from the pool, sometimes fresh, sometimes a corner.
   function automatic logic [KEY_W-1:0] pick_key();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) return key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (pick < 90) return $urandom;
      return corner_words[$urandom_range(0, 3)];
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 9) == 0) return corner_words[$urandom_range(0, 3)];
      return $urandom;
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Sweep the register through its extremes while empty, then settle on a
   // capacity for the run: small, mid or clamped high, left to the seed.
   task automatic test_capacity_setup();
      logic [CAP_W-1:0] cap;
      write_capacity(5'd31);
      write_capacity(5'd0);
      write_capacity(CAP_RESET);
      case ($urandom_range(0, 3))
         0: cap = CAP_W'($urandom_range(0, 1));
         1: cap = CAP_W'($urandom_range(16, 31));
         default: cap = CAP_W'($urandom_range(2, 15));
      endcase
      write_capacity(cap);
      key_pool.delete();
      repeat (usable_entries() + 4) key_pool.push_back($urandom);
   endtask

   // Miss on an empty cache, corner keys and values, an update, and a stored
   // all-ones value that must still come back as a hit.
   task automatic test_basic_operations();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_word(KIND_GET, 32'h1234_5678, 32'hffff_ffff);
      send_word(KIND_PUT, 32'h8000_0000, 32'h7fff_ffff);
      send_word(KIND_PUT, 32'h7fff_ffff, 32'h8000_0000);
      send_word(KIND_PUT, 32'h0000_0000, 32'hffff_ffff);
      send_word(KIND_GET, 32'h8000_0000, 32'h0000_0000);
      send_word(KIND_GET, 32'h7fff_ffff, 32'h0000_0000);
      send_word(KIND_GET, 32'h0000_0000, 32'h0000_0000);
      send_word(KIND_GET, 32'hffff_ffff, 32'h0000_0000);
      send_word(KIND_PUT, 32'h8000_0000, 32'h0000_0000);
      send_word(KIND_GET, 32'h8000_0000, 32'h5555_aaaa);
      settle_cache();
   endtask

   // Fill past capacity with fresh keys: the oldest one must be gone and the
   // newest one present.
   task automatic test_eviction();
      logic [KEY_W-1:0] first_key;
      logic [KEY_W-1:0] last_key;
      first_key = $urandom;
      last_key  = first_key;
      send_word(KIND_PUT, first_key, $urandom);
      repeat (usable_entries()) begin
         last_key = $urandom;
         send_word(KIND_PUT, last_key, $urandom);
      end
      send_word(KIND_GET, first_key, 32'h0);
      send_word(KIND_GET, last_key, 32'h0);
      settle_cache();
   endtask

   // Capacity writes with entries present must leave the register alone.
   task automatic test_capacity_locked();
      write_capacity(5'd31);
      write_capacity(5'd0);
   endtask

   // Random gets and puts over the key pool under one idling profile.
   task automatic test_random_traffic(input int words, input int send_pct,
                                      input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      repeat (words) begin
         if ($urandom_range(0, 1) == 0)
            send_word(KIND_GET, pick_key(), $urandom);
         else
            send_word(KIND_PUT, pick_key(), pick_value());
      end
      settle_cache();
      // Poke the register between phases; it is locked while entries exist.
      write_capacity(CAP_W'($urandom_range(0, 31)));
   endtask

   // Hold the response side off for a long stretch while gets keep coming,
   // so the cache fills its pipeline and drops request ready.
   task automatic test_backpressure();
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      rsp_hold_cycles = HOLD_OFF_CYCLES;
      repeat (60) begin
         if ($urandom_range(0, 4) == 0)
            send_word(KIND_PUT, pick_key(), pick_value());
         else
            send_word(KIND_GET, pick_key(), $urandom);
      end
      settle_cache();
   endtask

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.kind    = KIND_GET;
      req_bus.key     = '0;
      req_bus.value   = '0;
      rsp_bus.ready   = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.data    = '0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      rsp_hold_cycles = 0;
      error_count     = 0;
      quiet_cycles    = 0;
      for (int i = 0; i < DEF_ENTRIES; i++) begin
         shadow_keys[i]   = '0;
         shadow_values[i] = '0;
         shadow_valid[i]  = 1'b0;
         shadow_rank[i]   = 0;
      end
      shadow_count    = 0;
      shadow_capacity = CAP_RESET;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_capacity_setup();
      test_basic_operations();
      test_eviction();
      test_capacity_locked();
      test_random_traffic(340, 0, 0);
      test_random_traffic(340, 75, 0);
      test_random_traffic(340, 0, 75);
      test_random_traffic(340, 18, 18);
      test_backpressure();

      // Wait out any stray response before the verdict.
      settle_cache();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/lrc_pkg.sv
src/lrc_channels.sv
src/lrc_store.sv
src/lru_key_value_cache_top.sv
src/lrc_checker.sv
test/lru_key_value_cache_top_test.sv
